[rtl/core/lpcd_pkg.sv]
// Shared types, codes and helpers for the length-prefixed command deframer.
// Depends on nothing; every other file of the block imports this package.
`default_nettype none

package lpcd_pkg;

   // Frame delimiters
   localparam logic [7:0] START_DELIM = 8'h3C;
   localparam logic [7:0] END_DELIM   = 8'h3E;

   // Parser phases
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_TOTAL  = 3'd1;
   localparam logic [2:0] PH_CMDLEN = 3'd2;
   localparam logic [2:0] PH_CMD    = 3'd3;
   localparam logic [2:0] PH_FMTLEN = 3'd4;
   localparam logic [2:0] PH_FMT    = 3'd5;
   localparam logic [2:0] PH_DATA   = 3'd6;
   localparam logic [2:0] PH_END    = 3'd7;

   // Result kinds
   localparam logic [2:0] KIND_CMD  = 3'd0;
   localparam logic [2:0] KIND_FMT  = 3'd1;
   localparam logic [2:0] KIND_DATA = 3'd2;
   localparam logic [2:0] KIND_DONE = 3'd3;
   localparam logic [2:0] KIND_ERR  = 3'd4;

   // One result beat
   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] out_byte;
      logic [7:0] position;
      logic       last_in_section;
   } rsp_type;

   // Data byte count: total minus two minus both section lengths, floored at zero
   function automatic logic [7:0] data_count(input logic [7:0] total,
                                             input logic [7:0] cmd_len,
                                             input logic [7:0] fmt_len);
      logic [9:0] diff;
      diff = {2'b00, total} - 10'd2 - {2'b00, cmd_len} - {2'b00, fmt_len};
      return diff[9] ? 8'd0 : diff[7:0];
   endfunction

endpackage

`default_nettype wire

[rtl/core/lpcd_in_reg.sv]
// Input register of the deframer: holds one received byte until the parser takes it.
// Depends on lpcd_pkg (imported for house consistency of types).
`default_nettype none

module lpcd_in_reg (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       take,
   output logic            held_valid,
   output logic [7:0]      held_byte
);
   import lpcd_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       accept;

   // Stall only while a held beat cannot move on this cycle
   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   // Load a new beat or drop the one the parser took
   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (accept) begin
         valid_in = 1'b1;
         byte_in  = req_rx_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

endmodule

`default_nettype wire

[rtl/core/lpcd_parse.sv]
// Frame parser of the deframer: phase, lengths and section counters, one byte per step.
// Depends on lpcd_pkg for phase codes, result kinds, rsp_type and data_count.
`default_nettype none

module lpcd_parse (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic [7:0]       rx_byte,
   output logic                  res_valid,
   output lpcd_pkg::rsp_type     res
);
   import lpcd_pkg::*;

   logic [2:0] phase_ff,  phase_in;
   logic [7:0] total_ff,  total_in;
   logic [7:0] cmd_len_ff, cmd_len_in;
   logic [7:0] fmt_len_ff, fmt_len_in;
   logic [7:0] remain_ff, remain_in;
   logic [7:0] index_ff,  index_in;
   logic       last;
   logic [7:0] count_now;
   logic [7:0] count_fmtlen;
   logic [2:0] sect_kind;

   assign last         = (remain_ff <= 8'd1);
   assign count_now    = data_count(total_ff, cmd_len_ff, fmt_len_ff);
   assign count_fmtlen = data_count(total_ff, cmd_len_ff, rx_byte);

   always_comb begin
      case (phase_ff)
         PH_CMD:  sect_kind = KIND_CMD;
         PH_FMT:  sect_kind = KIND_FMT;
         default: sect_kind = KIND_DATA;
      endcase
   end

   // Decode one byte against the current phase
   always_comb begin
      phase_in   = phase_ff;
      total_in   = total_ff;
      cmd_len_in = cmd_len_ff;
      fmt_len_in = fmt_len_ff;
      remain_in  = remain_ff;
      index_in   = index_ff;
      res_valid  = 1'b0;
      res        = '0;
      case (phase_ff)
         PH_IDLE: begin
            if (rx_byte == START_DELIM) begin
               phase_in = PH_TOTAL;
            end else begin
               res_valid = 1'b1;
               res.kind  = KIND_ERR;
            end
         end
         PH_TOTAL: begin
            total_in = rx_byte;
            phase_in = PH_CMDLEN;
         end
         PH_CMDLEN: begin
            cmd_len_in = rx_byte;
            index_in   = 8'd0;
            remain_in  = rx_byte;
            phase_in   = (rx_byte != 8'd0) ? PH_CMD : PH_FMTLEN;
         end
         PH_FMTLEN: begin
            fmt_len_in = rx_byte;
            index_in   = 8'd0;
            if (rx_byte != 8'd0) begin
               phase_in  = PH_FMT;
               remain_in = rx_byte;
            end else begin
               // Empty format section: go straight to data or the end
               phase_in  = (count_fmtlen != 8'd0) ? PH_DATA : PH_END;
               remain_in = count_fmtlen;
            end
         end
         PH_CMD, PH_FMT, PH_DATA: begin
            res_valid           = 1'b1;
            res.kind            = sect_kind;
            res.out_byte        = rx_byte;
            res.position        = index_ff;
            res.last_in_section = last;
            index_in            = index_ff + 8'd1;
            remain_in           = remain_ff - 8'd1;
            if (last) begin
               index_in = 8'd0;
               case (phase_ff)
                  PH_CMD: begin
                     phase_in  = PH_FMTLEN;
                     remain_in = 8'd0;
                  end
                  PH_FMT: begin
                     phase_in  = (count_now != 8'd0) ? PH_DATA : PH_END;
                     remain_in = count_now;
                  end
                  default: begin
                     phase_in  = PH_END;
                     remain_in = 8'd0;
                  end
               endcase
            end
         end
         default: begin
            // End delimiter expected
            phase_in  = PH_IDLE;
            res_valid = 1'b1;
            if (rx_byte == END_DELIM) begin
               res.kind     = KIND_DONE;
               res.out_byte = count_now;
            end else begin
               res.kind = KIND_ERR;
            end
         end
      endcase
   end

   // Advance state only when the byte is consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         total_ff   <= 8'd0;
         cmd_len_ff <= 8'd0;
         fmt_len_ff <= 8'd0;
         remain_ff  <= 8'd0;
         index_ff   <= 8'd0;
      end else if (step) begin
         phase_ff   <= phase_in;
         total_ff   <= total_in;
         cmd_len_ff <= cmd_len_in;
         fmt_len_ff <= fmt_len_in;
         remain_ff  <= remain_in;
         index_ff   <= index_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/lpcd_out_reg.sv]
// Result register of the deframer with one skid entry behind it.
// Depends on lpcd_pkg for rsp_type.
`default_nettype none

module lpcd_out_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire lpcd_pkg::rsp_type push_data,
   output logic                   ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output lpcd_pkg::rsp_type      rsp_data
);
   import lpcd_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    pop;

   assign pop   = main_valid_ff && !rsp_stall;
   assign ready = !skid_valid_ff;

   // Refill from the skid entry first, else take the new beat
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

endmodule

`default_nettype wire

[rtl/core/length_prefixed_command_deframer.sv]
// Top level of the length-prefixed command deframer.
// Depends on lpcd_pkg, lpcd_in_reg, lpcd_parse and lpcd_out_reg.
//
// Parses '<' total cmd_len cmd... fmt_len fmt... data... '>' frames one byte per beat
// and returns at most one result beat per received byte: a tagged command, format or
// data byte, a frame-done beat carrying the data count, or a delimiter error. The block
// takes one byte every clock while req_stall is low. An accepted byte is held in the input
// register until the result side has room, is then parsed, and its result is loaded into
// the result register, from which it shows on the rsp_ ports. A skid entry behind the
// result register lets input keep flowing while rsp_stall is high, so req_stall rises
// only once that skid entry is also occupied and a byte is waiting in the input register.
`default_nettype none

module length_prefixed_command_deframer (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [2:0]      rsp_kind,
   output logic [7:0]      rsp_out_byte,
   output logic [7:0]      rsp_position,
   output logic            rsp_last_in_section
);
   import lpcd_pkg::*;

   logic       held_valid;
   logic [7:0] held_byte;
   logic       out_ready;
   logic       step;
   logic       res_valid;
   rsp_type    res;
   rsp_type    rsp_data;

   // Consume the held byte whenever the result side has room
   assign step = held_valid && out_ready;

   lpcd_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .take        (step),
      .held_valid  (held_valid),
      .held_byte   (held_byte)
   );

   lpcd_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rx_byte   (held_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   lpcd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .push      (step && res_valid),
      .push_data (res),
      .ready     (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_kind            = rsp_data.kind;
   assign rsp_out_byte        = rsp_data.out_byte;
   assign rsp_position        = rsp_data.position;
   assign rsp_last_in_section = rsp_data.last_in_section;

endmodule

`default_nettype wire

[rtl/core/lpcd_checker.sv]
// Port-level checker for the length-prefixed command deframer, bound to the top level.
// Depends on lpcd_pkg for result kind codes.
`default_nettype none

module lpcd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [2:0] rsp_kind,
   input wire logic [7:0] rsp_out_byte,
   input wire logic [7:0] rsp_position,
   input wire logic       rsp_last_in_section
);
   import lpcd_pkg::*;

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_out_byte)
         && $stable(rsp_position) && $stable(rsp_last_in_section))
      else $error("stalled result beat changed");

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // Error beats carry nothing
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ERR |->
         rsp_out_byte == 8'd0 && rsp_position == 8'd0 && !rsp_last_in_section)
      else $error("error beat with payload");

   // Frame-done beats have no position and no section end
   a_done_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DONE |-> rsp_position == 8'd0 && !rsp_last_in_section)
      else $error("frame-done beat with section fields");

   // Input is never held off while the result side is free
   a_no_stall_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result register");

endmodule

bind length_prefixed_command_deframer lpcd_checker u_lpcd_checker (
   .clock               (clock),
   .reset               (reset),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_kind            (rsp_kind),
   .rsp_out_byte        (rsp_out_byte),
   .rsp_position        (rsp_position),
   .rsp_last_in_section (rsp_last_in_section)
);

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the length-prefixed command deframer.
// Depends on lpcd_pkg and length_prefixed_command_deframer; drives directed then random frames.

module tb;
   import lpcd_pkg::*;

   // Directed rows: check against the parser model, expect nothing, or expect a typed beat
   typedef enum logic [1:0] {ROW_MODEL, ROW_NONE, ROW_LIT} row_mode_t;

   typedef struct packed {
      logic [7:0] rx;
      row_mode_t  mode;
      rsp_type    lit;
   } dir_row_t;

   logic       clock;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_stall   = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic [2:0] rsp_kind;
   logic [7:0] rsp_out_byte;
   logic [7:0] rsp_position;
   logic       rsp_last_in_section;

   // Parser model state
   logic [2:0] ps_phase;
   logic [7:0] ps_total;
   logic [7:0] ps_cmd_len;
   logic [7:0] ps_fmt_len;
   logic [7:0] ps_left;
   logic [7:0] ps_index;

   rsp_type     pending_rsp[$];
   dir_row_t    directed_rows[$];
   bit          quiet = 1'b0;
   int unsigned bytes_sent = 0;
   int unsigned rsp_count = 0;
   int unsigned n_section = 0;
   int unsigned n_done = 0;
   int unsigned n_err = 0;
   int unsigned mismatches = 0;

   length_prefixed_command_deframer u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_position        (rsp_position),
      .rsp_last_in_section (rsp_last_in_section)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #1000000;
      $display("FAIL");
      $finish;
   end

   // Data bytes the current frame carries, floored at zero
   function automatic logic [7:0] frame_data_bytes();
      int d;
      d = int'(ps_total) - 2 - int'(ps_cmd_len) - int'(ps_fmt_len);
      return (d < 0) ? 8'd0 : 8'(d);
   endfunction

   // Advance the parser model by one received byte
   task automatic parse_byte(input logic [7:0] b, output bit hit, output rsp_type r);
      logic [7:0] n;
      hit = 1'b0;
      r   = '0;
      case (ps_phase)
         PH_IDLE: begin
            if (b == START_DELIM) ps_phase = PH_TOTAL;
            else begin
               hit    = 1'b1;
               r.kind = KIND_ERR;
            end
         end
         PH_TOTAL: begin
            ps_total = b;
            ps_phase = PH_CMDLEN;
         end
         PH_CMDLEN: begin
            ps_cmd_len = b;
            ps_phase   = (b != 8'd0) ? PH_CMD : PH_FMTLEN;
            ps_left    = b;
            ps_index   = 8'd0;
         end
         PH_FMTLEN: begin
            ps_fmt_len = b;
            ps_index   = 8'd0;
            if (b != 8'd0) begin
               ps_phase = PH_FMT;
               ps_left  = b;
            end else begin
               n        = frame_data_bytes();
               ps_phase = (n != 8'd0) ? PH_DATA : PH_END;
               ps_left  = n;
            end
         end
         PH_CMD, PH_FMT, PH_DATA: begin
            hit    = 1'b1;
            r.kind = (ps_phase == PH_CMD) ? KIND_CMD :
                     (ps_phase == PH_FMT) ? KIND_FMT : KIND_DATA;
            r.out_byte        = b;
            r.position        = ps_index;
            r.last_in_section = (ps_left <= 8'd1);
            ps_index = ps_index + 8'd1;
            ps_left  = ps_left - 8'd1;
            // Close the section and move to whatever follows it
            if (r.last_in_section) begin
               ps_index = 8'd0;
               if (ps_phase == PH_CMD) begin
                  ps_phase = PH_FMTLEN;
                  ps_left  = 8'd0;
               end else if (ps_phase == PH_FMT) begin
                  n        = frame_data_bytes();
                  ps_phase = (n != 8'd0) ? PH_DATA : PH_END;
                  ps_left  = n;
               end else begin
                  ps_phase = PH_END;
                  ps_left  = 8'd0;
               end
            end
         end
         default: begin
            ps_phase = PH_IDLE;
            hit      = 1'b1;
            if (b == END_DELIM) begin
               r.kind     = KIND_DONE;
               r.out_byte = frame_data_bytes();
            end else r.kind = KIND_ERR;
         end
      endcase
   endtask

   task automatic add_row(input logic [7:0] rx, input row_mode_t mode, input logic [2:0] k,
                          input logic [7:0] ob, input logic [7:0] pos, input logic fin);
      dir_row_t row;
      row.rx  = rx;
      row.mode = mode;
      row.lit = '{k, ob, pos, fin};
      directed_rows.push_back(row);
   endtask

   // Offer one beat after a random gap, wait for acceptance, record what it should cause
   task automatic send_byte(input logic [7:0] b, input row_mode_t mode, input rsp_type lit);
      int unsigned gap;
      bit          hit;
      rsp_type     want;
      gap = quiet ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      parse_byte(b, hit, want);
      if (mode == ROW_LIT) pending_rsp.push_back(lit);
      else if (mode == ROW_MODEL && hit) pending_rsp.push_back(want);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Stimulus: directed table, then random frames mixed with noise and broken frames
   initial begin : stim
      logic [7:0]  frame_bytes[$];
      logic [7:0]  t;
      int unsigned c, f, dn, keep, pick, i;
      int          dcnt;

      ps_phase   = PH_IDLE;
      ps_total   = 8'd0;
      ps_cmd_len = 8'd0;
      ps_fmt_len = 8'd0;
      ps_left    = 8'd0;
      ps_index   = 8'd0;

      // Bad start bytes after reset, at both byte extremes
      add_row(8'h00, ROW_LIT, KIND_ERR, 8'd0, 8'd0, 1'b0);
      add_row(8'hFF, ROW_LIT, KIND_ERR, 8'd0, 8'd0, 1'b0);
      // Full frame with an empty format section and one data byte
      add_row(START_DELIM, ROW_NONE, KIND_CMD, 8'd0, 8'd0, 1'b0);
      add_row(8'd5, ROW_NONE, KIND_CMD, 8'd0, 8'd0, 1'b0);
      add_row(8'd2, ROW_NONE, KIND_CMD, 8'd0, 8'd0, 1'b0);
      add_row(8'h00, ROW_MODEL, KIND_CMD, 8'd0, 8'd0, 1'b0);
      add_row(8'hFF, ROW_MODEL, KIND_CMD, 8'd0, 8'd0, 1'b0);
      add_row(8'd0, ROW_NONE, KIND_CMD, 8'd0, 8'd0, 1'b0);
      add_row(8'hAA, ROW_MODEL, KIND_CMD, 8'd0, 8'd0, 1'b0);
      add_row(END_DELIM, ROW_LIT, KIND_DONE, 8'd1, 8'd0, 1'b0);
      // Empty command, short total, then a bad end byte
      add_row(START_DELIM, ROW_NONE, KIND_CMD, 8'd0, 8'd0, 1'b0);
      add_row(8'd0, ROW_NONE, KIND_CMD, 8'd0, 8'd0, 1'b0);
      add_row(8'd0, ROW_NONE, KIND_CMD, 8'd0, 8'd0, 1'b0);
      add_row(8'd1, ROW_NONE, KIND_CMD, 8'd0, 8'd0, 1'b0);
      add_row(8'h55, ROW_MODEL, KIND_CMD, 8'd0, 8'd0, 1'b0);
      add_row(START_DELIM, ROW_LIT, KIND_ERR, 8'd0, 8'd0, 1'b0);
      // Both sections empty, no data
      add_row(START_DELIM, ROW_NONE, KIND_CMD, 8'd0, 8'd0, 1'b0);
      add_row(8'd2, ROW_NONE, KIND_CMD, 8'd0, 8'd0, 1'b0);
      add_row(8'd0, ROW_NONE, KIND_CMD, 8'd0, 8'd0, 1'b0);
      add_row(8'd0, ROW_NONE, KIND_CMD, 8'd0, 8'd0, 1'b0);
      add_row(END_DELIM, ROW_LIT, KIND_DONE, 8'd0, 8'd0, 1'b0);
      // End delimiter while idle is a bad start
      add_row(END_DELIM, ROW_LIT, KIND_ERR, 8'd0, 8'd0, 1'b0);

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (i = 0; i < directed_rows.size(); i++)
         send_byte(directed_rows[i].rx, directed_rows[i].mode, directed_rows[i].lit);

      // Random frames until enough bytes have gone in
      while (bytes_sent < directed_rows.size() + 600) begin
         quiet = ($urandom_range(0, 3) == 0);
         pick  = $urandom_range(0, 99);
         frame_bytes.delete();
         if (pick < 15) begin
            // Noise between frames
            repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            c  = ($urandom_range(0, 31) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
            f  = $urandom_range(0, 6);
            dn = $urandom_range(0, 8);
            t  = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : 8'(2 + c + f + dn);
            dcnt = int'(t) - 2 - int'(c) - int'(f);
            frame_bytes.push_back(START_DELIM);
            frame_bytes.push_back(t);
            frame_bytes.push_back(8'(c));
            repeat (c) frame_bytes.push_back(8'($urandom_range(0, 255)));
            frame_bytes.push_back(8'(f));
            repeat (f) frame_bytes.push_back(8'($urandom_range(0, 255)));
            if (dcnt > 0) repeat (dcnt) frame_bytes.push_back(8'($urandom_range(0, 255)));
            frame_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                              : END_DELIM);
            // Break some frames: corrupt one byte
            if (pick < 20)
               frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = 8'($urandom_range(0, 255));
         end
         // Truncate some frames so the next one lands mid-parse
         keep = (pick >= 20 && pick < 25) ? $urandom_range(1, frame_bytes.size() - 1)
                                          : frame_bytes.size();
         for (i = 0; i < keep; i++) send_byte(frame_bytes[i], ROW_MODEL, '0);
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      // Drain, then give the pipeline time to show any stray beat
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      $display("Sent %0d bytes; checked %0d section bytes, %0d completed frames, %0d errors",
               bytes_sent, n_section, n_done, n_err);
      if (mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   // Result side: random stall per beat, plus one long hold-off to back the block up
   initial begin : drain
      int unsigned wait_cycles;
      bit          held;
      held = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (!held && rsp_count >= 100) begin
            held        = 1'b1;
            wait_cycles = 300;
         end else wait_cycles = quiet ? 0 : $urandom_range(0, 13);
         if (wait_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Compare every accepted result beat with the oldest expectation
   always @(posedge clock) begin : check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         case (rsp_kind)
            KIND_DONE: n_done++;
            KIND_ERR:  n_err++;
            default:   n_section++;
         endcase
         if (pending_rsp.size() == 0) begin
            $error("unexpected result beat: kind %0d byte %0d", rsp_kind, rsp_out_byte);
            mismatches++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
               mismatches++;
            end
            if (rsp_out_byte !== want.out_byte) begin
               $error("out_byte: expected %0d, got %0d", want.out_byte, rsp_out_byte);
               mismatches++;
            end
            if (rsp_position !== want.position) begin
               $error("position: expected %0d, got %0d", want.position, rsp_position);
               mismatches++;
            end
            if (rsp_last_in_section !== want.last_in_section) begin
               $error("last_in_section: expected %0d, got %0d",
                      want.last_in_section, rsp_last_in_section);
               mismatches++;
            end
         end
      end
   end

endmodule
